[hdl/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, codes and the segment table for the training segment
// sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int unsigned IDX_W   = 4;
    localparam int unsigned LEN_W   = 13;
    localparam int unsigned UNITS_W = 16;
    localparam int unsigned MD_W    = 7;
    localparam int unsigned SIG_W   = 3;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_ROLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MD_LENGTH   = 1'd1;

    // commands
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // segment codes
    localparam logic [SIG_W-1:0] SIG_SILENCE = 3'd0;
    localparam logic [SIG_W-1:0] SIG_S       = 3'd1;
    localparam logic [SIG_W-1:0] SIG_SBAR    = 3'd2;
    localparam logic [SIG_W-1:0] SIG_MD      = 3'd3;
    localparam logic [SIG_W-1:0] SIG_PP      = 3'd4;
    localparam logic [SIG_W-1:0] SIG_TRN     = 3'd5;
    localparam logic [SIG_W-1:0] SIG_J       = 3'd6;
    localparam logic [SIG_W-1:0] SIG_NONE    = 3'd7;

    // segment lengths
    localparam logic [LEN_W-1:0] LEN_SILENCE = 13'd70;
    localparam logic [LEN_W-1:0] LEN_S       = 13'd128;
    localparam logic [LEN_W-1:0] LEN_SBAR    = 13'd16;
    localparam logic [LEN_W-1:0] MD_UNIT_MS  = 13'd35;
    localparam logic [LEN_W-1:0] LEN_PP      = 13'd288;
    localparam logic [LEN_W-1:0] LEN_TRN     = 13'd512;

    typedef struct packed {
        logic             valid;
        logic [SIG_W-1:0] sig;
        logic             ms;
        logic [LEN_W-1:0] len;
    } t_seg;

    typedef struct packed {
        logic             accepted;
        logic [SIG_W-1:0] signal;
        logic             in_ms;
        logic [LEN_W-1:0] duration;
        logic [LEN_W-1:0] elapsed;
        logic             complete;
    } t_result;

    // segment at position idx for the given role and MD length
    function automatic t_seg seg_lookup(input logic [IDX_W-1:0] idx,
                                        input logic role,
                                        input logic [MD_W-1:0] md);
        t_seg         s;
        logic [IDX_W:0] j;
        s = '{valid: 1'b0, sig: SIG_NONE, ms: 1'b0, len: '0};
        j = {1'b0, idx} - {{IDX_W{1'b0}}, role};
        if (md == '0 && j >= 5'd2) begin
            j = j + 5'd3;
        end
        if (role && idx == '0) begin
            s = '{valid: 1'b1, sig: SIG_SILENCE, ms: 1'b1, len: LEN_SILENCE};
        end else begin
            case (j)
                5'd0: s = '{valid: 1'b1, sig: SIG_S,    ms: 1'b0, len: LEN_S};
                5'd1: s = '{valid: 1'b1, sig: SIG_SBAR, ms: 1'b0, len: LEN_SBAR};
                5'd2: s = '{valid: 1'b1, sig: SIG_MD,   ms: 1'b1,
                            len: LEN_W'(md) * MD_UNIT_MS};
                5'd3: s = '{valid: 1'b1, sig: SIG_S,    ms: 1'b0, len: LEN_S};
                5'd4: s = '{valid: 1'b1, sig: SIG_SBAR, ms: 1'b0, len: LEN_SBAR};
                5'd5: s = '{valid: 1'b1, sig: SIG_PP,   ms: 1'b0, len: LEN_PP};
                5'd6: s = '{valid: 1'b1, sig: SIG_TRN,  ms: 1'b0, len: LEN_TRN};
                5'd7: s = '{valid: 1'b1, sig: SIG_J,    ms: 1'b0, len: '0};
                default: s = '{valid: 1'b0, sig: SIG_NONE, ms: 1'b0, len: '0};
            endcase
        end
        return s;
    endfunction

endpackage

[hdl/tss_step.sv]
// ----------------------------------------------------------------------------
// tss_step
// Sequence position registers and the combinational step that applies one
// request and forms its result.
// ----------------------------------------------------------------------------
module tss_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic                          i_cmd,
    input  logic [tss_pkg::UNITS_W-1:0]   i_units,
    input  logic                          i_answer_role,
    input  logic [tss_pkg::MD_W-1:0]      i_md_length,
    output tss_pkg::t_result              o_result
);

    logic [tss_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [tss_pkg::LEN_W-1:0] r_el, n_el;
    logic                      r_done, n_done;

    tss_pkg::t_seg             cur, nxt;
    logic [tss_pkg::LEN_W-1:0] remain, sum;
    logic                      accepted;

    always_comb begin
        cur      = tss_pkg::seg_lookup(r_idx, i_answer_role, i_md_length);
        remain   = (cur.len > r_el) ? cur.len - r_el : '0;
        sum      = r_el + i_units[tss_pkg::LEN_W-1:0];
        n_idx    = r_idx;
        n_el     = r_el;
        n_done   = r_done;
        accepted = 1'b0;
        if (i_cmd == tss_pkg::CMD_RESTART) begin
            n_idx    = '0;
            n_el     = '0;
            n_done   = 1'b0;
            accepted = 1'b1;
        end else if (!r_done && cur.valid) begin
            if (cur.len == '0) begin
                n_idx    = r_idx + tss_pkg::IDX_W'(1);
                n_el     = '0;
                accepted = 1'b1;
            end else if (i_units <= tss_pkg::UNITS_W'(remain)) begin
                accepted = 1'b1;
                n_el     = sum;
                if (sum == cur.len) begin
                    n_idx = r_idx + tss_pkg::IDX_W'(1);
                    n_el  = '0;
                end
            end
        end
        nxt = tss_pkg::seg_lookup(n_idx, i_answer_role, i_md_length);
        if (accepted && !nxt.valid) begin
            n_done = 1'b1;
        end
        o_result.accepted = accepted;
        o_result.complete = n_done;
        if (!n_done && nxt.valid) begin
            o_result.signal   = nxt.sig;
            o_result.in_ms    = nxt.ms;
            o_result.duration = nxt.len;
            o_result.elapsed  = n_el;
        end else begin
            o_result.signal   = tss_pkg::SIG_NONE;
            o_result.in_ms    = 1'b0;
            o_result.duration = '0;
            o_result.elapsed  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_el   <= '0;
            r_done <= 1'b0;
        end else if (i_take) begin
            r_idx  <= n_idx;
            r_el   <= n_el;
            r_done <= n_done;
        end
    end

endmodule

[hdl/tss_out_buf.sv]
// ----------------------------------------------------------------------------
// tss_out_buf
// Result register with a skid entry, so a request is taken while a result
// waits at the output.
// ----------------------------------------------------------------------------
module tss_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tss_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output tss_pkg::t_result o_data
);

    logic             r_out_v, r_skid_v;
    tss_pkg::t_result r_out, r_skid;
    logic             pop;

    assign pop     = r_out_v && !i_stall;
    assign o_full  = r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_push;
            end
        end else if (i_push) begin
            if (!r_out_v) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end else if (i_push) begin
            if (!r_out_v) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

[hdl/training_segment_sequencer_core.sv]
// ----------------------------------------------------------------------------
// training_segment_sequencer_core
// Steps through the training transmit segments; one result per request.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_stall   i_cmd, i_units
//  result    out        o_out_valid / i_out_stall o_accepted .. o_complete
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
//  One request per cycle while o_in_stall is low; its result is registered.
//  The step is two segment-table lookups, a compare and an add on the position regs.
//  A two-entry output buffer takes one more request while a result is stalled.
//  Synchronous active-low reset clears position, config and output valids.
// ----------------------------------------------------------------------------
module training_segment_sequencer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic [tss_pkg::UNITS_W-1:0]      i_units,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_accepted,
    output logic [tss_pkg::SIG_W-1:0]        o_signal,
    output logic                             o_in_milliseconds,
    output logic [tss_pkg::LEN_W-1:0]        o_duration,
    output logic [tss_pkg::LEN_W-1:0]        o_elapsed,
    output logic                             o_complete,
    input  logic                             i_cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                     r_answer_role;
    logic [tss_pkg::MD_W-1:0] r_md_length;
    logic                     take, full;
    tss_pkg::t_result         step_res, out_res;

    assign o_in_stall = full;
    assign take       = i_in_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_answer_role <= 1'b0;
            r_md_length   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tss_pkg::CFG_ANSWER_ROLE: r_answer_role <= i_cfg_data[0];
                tss_pkg::CFG_MD_LENGTH:   r_md_length   <= i_cfg_data[tss_pkg::MD_W-1:0];
                default: ;
            endcase
        end
    end

    tss_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_cmd         (i_cmd),
        .i_units       (i_units),
        .i_answer_role (r_answer_role),
        .i_md_length   (r_md_length),
        .o_result      (step_res)
    );

    tss_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (step_res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_accepted        = out_res.accepted;
    assign o_signal          = out_res.signal;
    assign o_in_milliseconds = out_res.in_ms;
    assign o_duration        = out_res.duration;
    assign o_elapsed         = out_res.elapsed;
    assign o_complete        = out_res.complete;

endmodule

[hdl/tss_checker.sv]
// ----------------------------------------------------------------------------
// tss_checker
// Port-level checks on the sequencer result channel.
// ----------------------------------------------------------------------------
module tss_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_accepted,
    input logic [tss_pkg::SIG_W-1:0]   o_signal,
    input logic                        o_in_milliseconds,
    input logic [tss_pkg::LEN_W-1:0]   o_duration,
    input logic [tss_pkg::LEN_W-1:0]   o_elapsed,
    input logic                        o_complete
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_signal)
            && $stable(o_elapsed) && $stable(o_accepted) && $stable(o_complete))
        else $error("result changed while stalled");

    a_done_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_complete |-> o_signal == tss_pkg::SIG_NONE)
        else $error("complete result shows a segment");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_signal == tss_pkg::SIG_NONE |->
            o_duration == '0 && o_elapsed == '0 && !o_in_milliseconds)
        else $error("no segment but nonzero fields");

    a_ms_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_signal == tss_pkg::SIG_SILENCE || o_signal == tss_pkg::SIG_MD)
            |-> o_in_milliseconds)
        else $error("millisecond segment flagged as symbols");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind training_segment_sequencer_core tss_checker u_tss_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_accepted        (o_accepted),
    .o_signal          (o_signal),
    .o_in_milliseconds (o_in_milliseconds),
    .o_duration        (o_duration),
    .o_elapsed         (o_elapsed),
    .o_complete        (o_complete)
);
